// ===== hdl/dcpr_pkg.sv =====
// dcpr_pkg: shared widths, defaults and types of the dot column pitch resampler
// used by the front, queue, back and top level files of the block
// no dependencies
package dcpr_pkg;

    // default values of the top level parameters
    localparam int DEF_DOT_BITS   = 8;
    localparam int DEF_COUNT_BITS = 12;

    // configuration register widths and reset values
    localparam int PITCH_W = 5;
    localparam int LINE_W  = 12;
    localparam logic [PITCH_W-1:0] PITCH_RST = 5'd10;
    localparam logic [LINE_W-1:0]  LINE_RST  = 12'd1920;

    // register index codes, taken from paddr[2]
    localparam logic REG_PITCH = 1'b0;
    localparam logic REG_LINE  = 1'b1;

    // width of the repeat count of one job (at most ten copies)
    localparam int REP_W = 4;

    // control part of one job handed from the front to the back
    typedef struct packed {
        logic [REP_W-1:0] reps;   // copies of the main column
        logic             flush;  // merged column left over at end of line
        logic             last;   // job comes from the line's last column
    } t_job_ctl;

    // back end status seen by the top level
    typedef struct packed {
        logic busy;        // a job is being carried out
        logic count_zero;  // no column emitted yet in this line
    } t_back_status;

endpackage

// ===== hdl/dot_column_pitch_resampler_unit.sv =====
// dot_column_pitch_resampler_unit: top level of the dot column pitch resampler
// holds the configuration registers and joins front, job queue and back end
// depends on dcpr_pkg, dcpr_front, dcpr_queue, dcpr_back
//
// Use: source dot columns of one print line arrive on the s_axis channel, one
// column per transfer, with s_axis_tlast on the line's final column. Resampled
// columns leave on m_axis; m_axis_tuser is high for a real column and low for a
// bare end marker, m_axis_tlast marks the final result of the line.
// char_pitch (address 0) and line_dots (address 4) are written over the APB port
// while no line is in flight.
// A column passes through the job queue, the back end's job register and the
// output register. Throughput: the back end gives one output column per cycle
// while m_axis accepts it, and a column that causes no result still takes a
// step of its own. At pitch 1 a column causes ten results, at pass-through one.
// The two-entry job queue lets input keep flowing while a job is expanded.
// Reset clears pattern phase, merge state, column count and the queue, and sets
// char_pitch to 10 and line_dots to 1920. A stalled m_axis holds its result and
// backs up through the queue to s_axis_tready.
module dot_column_pitch_resampler_unit
    import dcpr_pkg::*;
#(
    parameter int DOT_BITS   = DEF_DOT_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // source columns
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((DOT_BITS+7)/8)*8-1:0]     s_axis_tdata,  // dot_column
    input  logic                              s_axis_tlast,  // line_last
    // resampled columns
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((DOT_BITS+7)/8)*8-1:0]     m_axis_tdata,  // out_column
    output logic                              m_axis_tuser,  // column_valid
    output logic                              m_axis_tlast,  // line_end
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int DATA_W = ((DOT_BITS + 7) / 8) * 8;
    localparam int JOB_W  = 2 * DOT_BITS + $bits(t_job_ctl);

    logic [PITCH_W-1:0]    r_pitch;
    logic [LINE_W-1:0]     r_line_dots;
    logic [COUNT_BITS-1:0] w_limit;

    logic                  w_q_full, w_push, w_pop, w_q_valid;
    logic [DOT_BITS-1:0]   w_f_col, w_f_fcol, w_b_col, w_b_fcol, w_out_col;
    t_job_ctl              w_f_ctl, w_b_ctl;
    t_back_status          w_bst;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch     <= PITCH_RST;
            r_line_dots <= LINE_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_LINE) r_line_dots <= pwdata[LINE_W-1:0];
            else                      r_pitch     <= pwdata[PITCH_W-1:0];
        end
    end

    assign prdata  = (paddr[2] == REG_PITCH) ? {{(32-PITCH_W){1'b0}}, r_pitch}
                                             : {{(32-LINE_W){1'b0}}, r_line_dots};
    assign w_limit = COUNT_BITS'(r_line_dots);

    // front: pattern phase and merging
    dcpr_front #(
        .DOT_BITS (DOT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pitch  (r_pitch),
        .i_valid  (s_axis_tvalid),
        .i_col    (s_axis_tdata[DOT_BITS-1:0]),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_col    (w_f_col),
        .o_fcol   (w_f_fcol),
        .o_ctl    (w_f_ctl)
    );

    // job queue
    dcpr_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_col, w_f_fcol, w_f_ctl}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  ({w_b_col, w_b_fcol, w_b_ctl})
    );

    // back: expansion, line limit and output register
    dcpr_back #(
        .DOT_BITS   (DOT_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (w_limit),
        .i_q_valid   (w_q_valid),
        .i_col       (w_b_col),
        .i_fcol      (w_b_fcol),
        .i_ctl       (w_b_ctl),
        .o_pop       (w_pop),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_col       (w_out_col),
        .o_col_valid (m_axis_tuser),
        .o_end       (m_axis_tlast),
        .o_status    (w_bst)
    );

    assign m_axis_tdata = DATA_W'(w_out_col);

    // a bare end marker carries a zero column and the line end mark
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("end marker malformed");

    // nothing new appears on the output while the back end has no job
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_bst.busy && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("output without a job");

    // the column count is back at zero while a line end result waits
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> w_bst.count_zero)
        else $error("column count not cleared at line end");

endmodule

// ===== hdl/dcpr_front.sv =====
// dcpr_front: accepts source columns, tracks the pitch pattern phase and the merge
// accumulator, and turns each column into one job for the back end
// depends on dcpr_pkg
module dcpr_front
    import dcpr_pkg::*;
#(
    parameter int DOT_BITS = DEF_DOT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PITCH_W-1:0]  i_pitch,
    input  logic                i_valid,
    input  logic [DOT_BITS-1:0] i_col,
    input  logic                i_last,
    output logic                o_ready,
    input  logic                i_q_full,
    output logic                o_push,
    output logic [DOT_BITS-1:0] o_col,
    output logic [DOT_BITS-1:0] o_fcol,
    output t_job_ctl            o_ctl
);

    // period of the merge pitches, zero elsewhere
    function automatic logic [PITCH_W-1:0] merge_period(input logic [PITCH_W-1:0] p);
        logic [PITCH_W-1:0] r;
        unique case (p)
            5'd11:        r = 5'd12;
            5'd12:        r = 5'd6;
            5'd13:        r = 5'd4;
            5'd15:        r = 5'd3;
            5'd19, 5'd20: r = 5'd2;
            default:      r = 5'd0;
        endcase
        return r;
    endfunction

    // pattern period of every pitch
    function automatic logic [PITCH_W-1:0] pattern_period(input logic [PITCH_W-1:0] p);
        logic [PITCH_W-1:0] r;
        unique case (p)
            5'd3, 5'd6:          r = 5'd3;
            5'd4:                r = 5'd2;
            5'd7, 5'd17:         r = 5'd12;
            5'd8:                r = 5'd4;
            5'd9:                r = 5'd8;
            5'd14, 5'd16, 5'd18: r = 5'd24;
            default:             r = (merge_period(p) != 5'd0) ? merge_period(p) : 5'd1;
        endcase
        return r;
    endfunction

    // phases below 21 that leave remainder two when divided by three
    function automatic logic third_drop(input logic [PITCH_W-1:0] ph);
        return (ph == 5'd2) || (ph == 5'd5) || (ph == 5'd8) || (ph == 5'd11) ||
               (ph == 5'd14) || (ph == 5'd17) || (ph == 5'd20);
    endfunction

    // copies of the column at a given phase for repeat and drop pitches
    function automatic logic [REP_W-1:0] copies(input logic [PITCH_W-1:0] p,
                                                input logic [PITCH_W-1:0] ph);
        logic [REP_W-1:0] r;
        unique case (p)
            5'd1:  r = 4'd10;
            5'd2:  r = 4'd5;
            5'd5:  r = 4'd2;
            5'd3:  r = (ph == 5'd2) ? 4'd4 : 4'd3;
            5'd4:  r = (ph == 5'd1) ? 4'd3 : 4'd2;
            5'd6:  r = (ph == 5'd2) ? 4'd1 : 4'd2;
            5'd7:  r = (ph < 5'd10 && ph[0]) ? 4'd2 : 4'd1;
            5'd8:  r = (ph == 5'd3) ? 4'd2 : 4'd1;
            5'd9:  r = (ph == 5'd7) ? 4'd2 : 4'd1;
            5'd14: r = (ph < 5'd21 && third_drop(ph)) ? 4'd0 : 4'd1;
            5'd16: begin
                if (ph < 5'd21) r = third_drop(ph) ? 4'd0 : 4'd1;
                else            r = (ph == 5'd23) ? 4'd1 : 4'd0;
            end
            5'd17: r = (ph < 5'd10 && ph[0]) ? 4'd0 : 4'd1;
            5'd18: r = (ph < 5'd22 && ph[0]) ? 4'd0 : 4'd1;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

    logic [PITCH_W-1:0]  r_phase, n_phase;
    logic [DOT_BITS-1:0] r_acc, n_acc;
    logic                r_pend, n_pend;

    logic [PITCH_W-1:0]  w_per, w_cf, w_ph, w_ph_inc;
    logic [DOT_BITS-1:0] w_merged;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // job and next pattern state for the column on the input
    always_comb begin
        w_per    = pattern_period(i_pitch);
        w_cf     = merge_period(i_pitch);
        w_ph     = (r_phase >= w_per) ? '0 : r_phase;
        w_merged = (r_pend ? r_acc : '0) | i_col;
        w_ph_inc = w_ph + 5'd1;
        n_phase  = (w_ph_inc >= w_per) ? '0 : w_ph_inc;
        n_acc    = r_acc;
        n_pend   = r_pend;
        o_col    = i_col;
        o_ctl    = '0;
        if (w_cf != 5'd0) begin
            o_col = w_merged;
            if (w_ph + 5'd2 == w_cf) begin
                n_acc  = w_merged;
                n_pend = 1'b1;
            end else if (w_ph_inc == w_cf) begin
                o_ctl.reps = 4'd1;
                n_acc      = i_col;
                n_pend     = 1'b1;
            end else begin
                o_ctl.reps = 4'd1;
                n_acc      = '0;
                n_pend     = 1'b0;
            end
        end else begin
            o_ctl.reps = copies(i_pitch, w_ph);
        end
        o_ctl.last  = i_last;
        o_ctl.flush = i_last && n_pend;
        o_fcol      = n_acc;
        // the line's last column clears the pattern state
        if (i_last) begin
            n_phase = '0;
            n_acc   = '0;
            n_pend  = 1'b0;
        end
    end

    // pattern state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_acc   <= '0;
            r_pend  <= 1'b0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
        end
    end

endmodule

// ===== hdl/dcpr_queue.sv =====
// dcpr_queue: two-entry job queue between the front and the back end
// depends on dcpr_pkg for the default width; width set by parameter
module dcpr_queue
    import dcpr_pkg::*;
#(
    parameter int WIDTH = 2 * DEF_DOT_BITS + $bits(t_job_ctl)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            priority if (i_push && !i_pop) r_fill <= r_fill + 2'd1;
            else if (i_pop && !i_push)     r_fill <= r_fill - 2'd1;
        end
    end

endmodule

// ===== hdl/dcpr_back.sv =====
// dcpr_back: carries out jobs one output column per cycle while the output
// can move, applies the line length limit, marks the line end and holds the
// output register; depends on dcpr_pkg
module dcpr_back
    import dcpr_pkg::*;
#(
    parameter int DOT_BITS   = DEF_DOT_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [COUNT_BITS-1:0] i_limit,
    input  logic                  i_q_valid,
    input  logic [DOT_BITS-1:0]   i_col,
    input  logic [DOT_BITS-1:0]   i_fcol,
    input  t_job_ctl              i_ctl,
    output logic                  o_pop,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [DOT_BITS-1:0]   o_col,
    output logic                  o_col_valid,
    output logic                  o_end,
    output t_back_status          o_status
);

    logic                  r_busy;
    logic [DOT_BITS-1:0]   r_col, r_fcol;
    logic [REP_W-1:0]      r_rem;
    logic                  r_flush, r_last, r_any;
    logic [COUNT_BITS-1:0] r_count;

    logic                  r_out_valid, r_out_cv, r_out_end;
    logic [DOT_BITS-1:0]   r_out_col;

    logic                  w_adv, w_full, w_has_copy, w_can_emit, w_more, w_at_limit;
    logic                  w_done, w_marker;
    logic [REP_W-1:0]      w_rem_n;
    logic                  w_flush_n;
    logic [COUNT_BITS:0]   w_count_inc;

    // one step of the current job per cycle while the output can move
    always_comb begin
        w_adv       = r_busy && (!r_out_valid || i_ready);
        w_full      = (r_count >= i_limit);
        w_has_copy  = (r_rem != '0);
        w_can_emit  = !w_full && (w_has_copy || r_flush);
        w_rem_n     = w_has_copy ? r_rem - 4'd1 : r_rem;
        w_flush_n   = w_has_copy ? r_flush : 1'b0;
        w_more      = (w_rem_n != '0) || w_flush_n;
        w_count_inc = {1'b0, r_count} + 1'b1;
        w_at_limit  = (w_count_inc >= {1'b0, i_limit});
        w_done      = !w_can_emit || !w_more || w_at_limit;
        w_marker    = !w_can_emit && r_last && !r_any;
        o_pop       = i_q_valid && (!r_busy || (w_adv && w_done));
    end

    // job register and column count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_any   <= 1'b0;
            r_count <= '0;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_col   <= i_col;
                r_fcol  <= i_fcol;
                r_rem   <= i_ctl.reps;
                r_flush <= i_ctl.flush;
                r_last  <= i_ctl.last;
                r_any   <= 1'b0;
            end else if (w_adv) begin
                if (w_done) r_busy <= 1'b0;
                if (w_can_emit) begin
                    r_rem   <= w_rem_n;
                    r_flush <= w_flush_n;
                    r_any   <= 1'b1;
                end
            end
            // a finished last job starts the next line's count
            if (w_adv) begin
                if (w_done && r_last) r_count <= '0;
                else if (w_can_emit)  r_count <= w_count_inc[COUNT_BITS-1:0];
            end
        end
    end

    // output register, refilled whenever it is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= w_adv && (w_can_emit || w_marker);
        end
        if (!r_out_valid || i_ready) begin
            r_out_col <= w_can_emit ? (w_has_copy ? r_col : r_fcol) : '0;
            r_out_cv  <= w_can_emit;
            r_out_end <= r_last && w_done;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_col                = r_out_col;
    assign o_col_valid          = r_out_cv;
    assign o_end                = r_out_end;
    assign o_status.busy        = r_busy;
    assign o_status.count_zero  = (r_count == '0);

endmodule
